>>> src/alls_pkg.sv
// Shared constants for the ambient light lux sampler.
// Holds register indexes, reset values, channel widths and Q16 coefficients.
// No dependencies.
package alls_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_SECONDS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 8'd1;
  localparam logic [7:0] CYCLE_SECONDS_RST = 8'd4;

  // Channel and result widths
  localparam int CHAN_W = 16;
  localparam int LUX_W  = 21;
  localparam logic [LUX_W-1:0] LUX_MAX = 21'd2000000;

  // Ratio test: ch1*100 against (ch0+ch1)*threshold, all exact
  localparam int CMP_W = 24;
  localparam logic [CMP_W-1:0] RATIO_SCALE = 24'd100;
  localparam logic [CMP_W-1:0] RATIO_LO    = 24'd45;
  localparam logic [CMP_W-1:0] RATIO_MID   = 24'd64;
  localparam logic [CMP_W-1:0] RATIO_HI    = 24'd85;

  // Q16 coefficients already scaled by ten, so one product layer gives lux*10*2^16
  localparam int KX_W  = 22;
  localparam int ACC_W = 38;
  localparam int FRAC_W = 16;
  localparam logic [KX_W-1:0] KX_A0 = 22'd1162810;  // 10 * 1.7743
  localparam logic [KX_W-1:0] KX_A1 = 22'd724760;   // 10 * 1.1059
  localparam logic [KX_W-1:0] KX_B0 = 22'd2803960;  // 10 * 4.2785
  localparam logic [KX_W-1:0] KX_B1 = 22'd1281100;  // 10 * 1.9548
  localparam logic [KX_W-1:0] KX_C0 = 22'd388370;   // 10 * 0.5926
  localparam logic [KX_W-1:0] KX_C1 = 22'd77660;    // 10 * 0.1185

endpackage

>>> src/ambient_light_lux_sampler_top.sv
// Top level of the ambient light lux sampler: tick stream in, lux stream out.
// Depends on alls_pkg for constants and coefficients.
//
// Each input beat is one one-second tick carrying the sensor's data-ready flag
// (in_tuser) and the two channel counts (in_tdata). A countdown fires on the
// first tick after reset and then every cycle_seconds+1 ticks; on a firing tick
// with the sensor present the channels are latched (if data is ready) and lux
// times ten is recomputed with the piecewise ratio formula. Every tick yields
// exactly one output beat: out_tuser says whether a measurement happened and
// out_tdata carries the latest lux*10. The block takes one beat per clock while
// the output is not stalled, through an input register, then a single pass
// through the ratio compare and one layer of constant multipliers into the
// result register. An output stall backs up into in_tready only once both
// registers are full. Configuration writes are taken at any time
// (cfg_ready is always high) but are meant for an idle block.
module ambient_light_lux_sampler_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Tick input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [15:0] chan_visible_ir, [31:16] chan_ir
  input  logic                            in_tuser,   // [0] data_ready
  // Result output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [20:0] lux_x10, [23:21] zero
  output logic                            out_tuser,  // [0] measured
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alls_pkg::CFG_DAT_W-1:0]  cfg_data
);

  // Configuration registers
  logic [7:0] cycle_seconds_r;
  logic       sensor_present_r;

  // Tick state
  logic [7:0]                    seconds_left_r, seconds_left_nxt;
  logic [alls_pkg::CHAN_W-1:0]   held_c0_r, held_c0_nxt;
  logic [alls_pkg::CHAN_W-1:0]   held_c1_r, held_c1_nxt;
  logic [alls_pkg::LUX_W-1:0]    last_lux_r, last_lux_nxt;

  // Input stage
  logic                          s0_valid_r;
  logic                          s0_ready_r;
  logic [alls_pkg::CHAN_W-1:0]   s0_c0_r;
  logic [alls_pkg::CHAN_W-1:0]   s0_c1_r;

  // Result stage
  logic                          out_valid_r;
  logic                          out_meas_r;
  logic [alls_pkg::LUX_W-1:0]    out_lux_r;

  logic in_fire, adv, cfg_fire, cycle_wr;
  logic fire, meas;

  // Datapath
  logic [alls_pkg::CHAN_W-1:0] c0, c1;
  logic [alls_pkg::CMP_W-1:0]  sum, hi, lim_lo, lim_mid, lim_hi;
  logic                        seg_a, seg_b, seg_c, chan_zero;
  logic [alls_pkg::ACC_W-1:0]  acc_a, acc_c, prod_p, prod_m, acc_b, acc;
  logic [alls_pkg::ACC_W-alls_pkg::FRAC_W-1:0] scaled;
  logic [alls_pkg::LUX_W-1:0]  lux_new;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign cycle_wr  = cfg_fire && (cfg_index == alls_pkg::REG_CYCLE_SECONDS) &&
                     (cfg_data != '0);
  assign adv       = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  // Countdown decision for the tick in the input stage
  assign fire = (seconds_left_r == '0);
  assign meas = fire && sensor_present_r;

  // Pick channels: fresh ones on a measuring tick with data ready
  always_comb begin
    held_c0_nxt = held_c0_r;
    held_c1_nxt = held_c1_r;
    if (adv && meas && s0_ready_r) begin
      held_c0_nxt = s0_c0_r;
      held_c1_nxt = s0_c1_r;
    end
  end
  assign c0 = (meas && s0_ready_r) ? s0_c0_r : held_c0_r;
  assign c1 = (meas && s0_ready_r) ? s0_c1_r : held_c1_r;

  // Exact ratio test by cross-multiplication
  assign sum       = alls_pkg::CMP_W'(c0) + alls_pkg::CMP_W'(c1);
  assign hi        = alls_pkg::CMP_W'(c1) * alls_pkg::RATIO_SCALE;
  assign lim_lo    = sum * alls_pkg::RATIO_LO;
  assign lim_mid   = sum * alls_pkg::RATIO_MID;
  assign lim_hi    = sum * alls_pkg::RATIO_HI;
  assign chan_zero = (sum == '0);
  assign seg_a     = hi < lim_lo;
  assign seg_b     = hi < lim_mid;
  assign seg_c     = hi < lim_hi;

  // One layer of constant products for all three segments
  assign acc_a  = alls_pkg::ACC_W'(c0) * alls_pkg::ACC_W'(alls_pkg::KX_A0) +
                  alls_pkg::ACC_W'(c1) * alls_pkg::ACC_W'(alls_pkg::KX_A1);
  assign prod_p = alls_pkg::ACC_W'(c0) * alls_pkg::ACC_W'(alls_pkg::KX_B0);
  assign prod_m = alls_pkg::ACC_W'(c1) * alls_pkg::ACC_W'(alls_pkg::KX_B1);
  assign acc_b  = (prod_p > prod_m) ? (prod_p - prod_m) : '0;
  assign acc_c  = alls_pkg::ACC_W'(c0) * alls_pkg::ACC_W'(alls_pkg::KX_C0) +
                  alls_pkg::ACC_W'(c1) * alls_pkg::ACC_W'(alls_pkg::KX_C1);

  // Select segment; zero when both channels are dark or ratio is too high
  always_comb begin
    priority if (chan_zero) begin
      acc = '0;
    end else if (seg_a) begin
      acc = acc_a;
    end else if (seg_b) begin
      acc = acc_b;
    end else if (seg_c) begin
      acc = acc_c;
    end else begin
      acc = '0;
    end
  end

  // Drop the fraction, saturate
  assign scaled  = acc[alls_pkg::ACC_W-1:alls_pkg::FRAC_W];
  assign lux_new = (scaled > (alls_pkg::ACC_W-alls_pkg::FRAC_W)'(alls_pkg::LUX_MAX)) ?
                   alls_pkg::LUX_MAX : scaled[alls_pkg::LUX_W-1:0];

  assign last_lux_nxt = (adv && meas) ? lux_new : last_lux_r;

  // Countdown: a cycle write reloads, else advance with each tick
  always_comb begin
    seconds_left_nxt = seconds_left_r;
    if (cycle_wr) begin
      seconds_left_nxt = cfg_data;
    end else if (adv) begin
      seconds_left_nxt = fire ? cycle_seconds_r : (seconds_left_r - 8'd1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_seconds_r  <= alls_pkg::CYCLE_SECONDS_RST;
      sensor_present_r <= 1'b0;
    end else if (cfg_fire) begin
      if (cycle_wr) begin
        cycle_seconds_r <= cfg_data;
      end
      if (cfg_index == alls_pkg::REG_SENSOR_PRESENT) begin
        sensor_present_r <= cfg_data[0];
      end
    end
  end

  // Tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_left_r <= '0;
      held_c0_r      <= '0;
      held_c1_r      <= '0;
      last_lux_r     <= '0;
    end else begin
      seconds_left_r <= seconds_left_nxt;
      held_c0_r      <= held_c0_nxt;
      held_c1_r      <= held_c1_nxt;
      last_lux_r     <= last_lux_nxt;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (adv) begin
        s0_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_ready_r <= in_tuser;
      s0_c0_r    <= in_tdata[15:0];
      s0_c1_r    <= in_tdata[31:16];
    end
    if (adv) begin
      out_meas_r <= meas;
      out_lux_r  <= last_lux_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_meas_r;
  assign out_tdata  = {3'b000, out_lux_r};

  // A nonzero cycle write reloads the countdown with that value
  a_cycle_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cycle_wr |=> (seconds_left_r == $past(cfg_data)))
    else $error("countdown not reloaded by cycle write");

  // A tick that does not fire, with no cycle write, decrements the countdown
  a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !fire && !cycle_wr) |=> (seconds_left_r == $past(seconds_left_r) - 8'd1))
    else $error("countdown did not decrement");

  // A tick without measurement reports the previous lux unchanged
  a_lux_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !meas) |=> (!out_tuser && (out_lux_r == $past(last_lux_r))))
    else $error("lux changed without a measurement");

  // Reported lux never exceeds the saturation limit
  a_lux_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_lux_r <= alls_pkg::LUX_MAX))
    else $error("lux out of range");

endmodule
